>>> rtl/spp_pkg.sv
// Shared types and constants for the stride prefetch predictor.
// No dependencies; every other file imports this package.
package spp_pkg;

   localparam int DEGREE_BITS     = 4;
   localparam int BLOCK_BITS      = 13;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 13;
   localparam int STAMP_BITS      = 32;
   localparam int JOB_QUEUE_DEPTH = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEGREE     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLOCK_SIZE = 2'd1;

   localparam logic [DEGREE_BITS-1:0] DEGREE_RESET = 4'd1;
   localparam logic [BLOCK_BITS-1:0]  BLOCK_RESET  = 13'd64;

   typedef enum logic [1:0] {
      MODE_INITIAL   = 2'd0,
      MODE_TRANSIENT = 2'd1,
      MODE_STEADY    = 2'd2,
      MODE_NOPRED    = 2'd3
   } mode_type;

   typedef enum logic [4:0] {
      FS_IDLE   = 5'b00001,
      FS_LOOKUP = 5'b00010,
      FS_SCAN   = 5'b00100,
      FS_UPDATE = 5'b01000,
      FS_STEP   = 5'b10000
   } front_state_type;

endpackage

>>> rtl/spp_if.sv
// Channel interfaces of the stride prefetch predictor: access, prefetch and register write.
// Depends on spp_pkg.
interface spp_req_if
   import spp_pkg::*;
#(
   parameter int ADDR_BITS = 48
);
   logic                 valid;
   logic                 ready;
   logic                 has_pc;
   logic [ADDR_BITS-1:0] pc;
   logic [ADDR_BITS-1:0] access_addr;

   modport source (output valid, has_pc, pc, access_addr, input ready);
   modport sink   (input valid, has_pc, pc, access_addr, output ready);
endinterface

interface spp_rsp_if
   import spp_pkg::*;
#(
   parameter int ADDR_BITS = 48
);
   logic                 valid;
   logic                 ready;
   logic [ADDR_BITS-1:0] prefetch_addr;
   logic                 last_of_run;

   modport source (output valid, prefetch_addr, last_of_run, input ready);
   modport sink   (input valid, prefetch_addr, last_of_run, output ready);
endinterface

interface spp_csr_if
   import spp_pkg::*;
;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/spp_front.sv
// Front end: configuration registers, prediction table, LRU victim scan, stride update.
// Emits one prefetch job per predicting hit when the degree is nonzero. Depends on spp_pkg and spp_if.
module spp_front
   import spp_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16,
   parameter int ADDR_BITS     = 48,
   parameter int MAX_DEGREE    = 8,
   parameter int CNT_BITS      = $clog2(MAX_DEGREE + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   spp_req_if.sink              req,
   spp_csr_if.sink              csr,
   output logic                 job_valid,
   input  logic                 job_ready,
   output logic [ADDR_BITS-1:0] job_addr,
   output logic [ADDR_BITS-1:0] job_step,
   output logic [CNT_BITS-1:0]  job_count
);

   localparam int IDX_BITS = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   front_state_type state_ff, state_in;

   logic [DEGREE_BITS-1:0] degree_ff;
   logic [BLOCK_BITS-1:0]  block_ff;
   logic [STAMP_BITS-1:0]  counter_ff;

   logic                 has_pc_ff;
   logic [ADDR_BITS-1:0] pc_ff;
   logic [ADDR_BITS-1:0] addr_ff;

   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [ADDR_BITS-1:0]     tag_ff    [TABLE_ENTRIES];
   logic [ADDR_BITS-1:0]     prev_ff   [TABLE_ENTRIES];
   logic [ADDR_BITS-1:0]     stride_ff [TABLE_ENTRIES];
   mode_type                 mode_ff   [TABLE_ENTRIES];
   logic [STAMP_BITS-1:0]    stamp_ff  [TABLE_ENTRIES];

   logic [IDX_BITS-1:0]   slot_ff, slot_in;
   logic [IDX_BITS-1:0]   scan_ff, scan_in;
   logic [IDX_BITS-1:0]   victim_ff, victim_in;
   logic [STAMP_BITS-1:0] best_ff, best_in;
   logic [ADDR_BITS-1:0]  new_stride_ff, new_stride_in;

   logic [TABLE_ENTRIES-1:0] hit_vec;
   logic                     any_hit, any_free;
   logic [IDX_BITS-1:0]      hit_idx, free_idx;

   logic                 wr_en;
   logic [IDX_BITS-1:0]  wr_idx;
   logic [ADDR_BITS-1:0] wr_prev;
   logic [ADDR_BITS-1:0] wr_stride;
   mode_type             wr_mode;

   logic [STAMP_BITS-1:0] scan_age;
   logic                  scan_take;
   logic                  correct;
   mode_type              cur_mode, upd_mode;

   logic [31:0]          low;
   logic [32:0]          mag;
   logic [ADDR_BITS-1:0] step;
   logic [CNT_BITS-1:0]  count;

   assign req.ready = (state_ff == FS_IDLE);
   assign csr.ready = 1'b1;

   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         hit_vec[i] = valid_ff[i] && (tag_ff[i] == pc_ff);
         if (hit_vec[i]) begin
            hit_idx = IDX_BITS'(i);
         end
         if (!valid_ff[i]) begin
            free_idx = IDX_BITS'(i);
         end
      end
   end

   assign any_hit  = |hit_vec;
   assign any_free = ~&valid_ff;

   assign scan_age  = counter_ff - stamp_ff[scan_ff];
   assign scan_take = (scan_ff == '0) || (scan_age > best_ff);

   assign cur_mode = mode_ff[slot_ff];
   assign correct  = (addr_ff == prev_ff[slot_ff] + stride_ff[slot_ff]);

   always_comb begin
      upd_mode      = cur_mode;
      new_stride_in = stride_ff[slot_ff];
      if (correct) begin
         upd_mode = (cur_mode == MODE_NOPRED) ? MODE_TRANSIENT : MODE_STEADY;
      end else if (cur_mode == MODE_STEADY) begin
         upd_mode = MODE_INITIAL;
      end else begin
         new_stride_in = addr_ff - prev_ff[slot_ff];
         upd_mode      = (cur_mode == MODE_INITIAL) ? MODE_TRANSIENT : MODE_NOPRED;
      end
   end

   always_comb begin
      low = new_stride_ff[31:0];
      if (low[31]) begin
         mag = 33'h1_0000_0000 - {1'b0, low};
      end else begin
         mag = {1'b0, low};
      end
      if (mag < 33'(block_ff)) begin
         step = low[31] ? (ADDR_BITS'(0) - ADDR_BITS'(block_ff)) : ADDR_BITS'(block_ff);
      end else begin
         step = ADDR_BITS'($signed(low));
      end
      if (32'(degree_ff) > 32'(MAX_DEGREE)) begin
         count = CNT_BITS'(MAX_DEGREE);
      end else begin
         count = CNT_BITS'(degree_ff);
      end
   end

   assign job_valid = (state_ff == FS_STEP) && (count != '0);
   assign job_addr  = addr_ff;
   assign job_step  = step;
   assign job_count = count;

   always_comb begin
      state_in  = state_ff;
      slot_in   = slot_ff;
      scan_in   = scan_ff;
      victim_in = victim_ff;
      best_in   = best_ff;
      wr_en     = 1'b0;
      wr_idx    = free_idx;
      wr_prev   = addr_ff;
      wr_stride = '0;
      wr_mode   = MODE_INITIAL;
      case (state_ff)
         FS_IDLE: begin
            if (req.valid) begin
               state_in = FS_LOOKUP;
            end
         end
         FS_LOOKUP: begin
            if (!has_pc_ff) begin
               state_in = FS_IDLE;
            end else if (any_hit) begin
               slot_in  = hit_idx;
               state_in = FS_UPDATE;
            end else if (any_free) begin
               wr_en    = 1'b1;
               state_in = FS_IDLE;
            end else begin
               scan_in  = '0;
               state_in = FS_SCAN;
            end
         end
         FS_SCAN: begin
            if (scan_take) begin
               victim_in = scan_ff;
               best_in   = scan_age;
            end
            if (scan_ff == IDX_BITS'(TABLE_ENTRIES - 1)) begin
               wr_en    = 1'b1;
               wr_idx   = victim_in;
               state_in = FS_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         FS_UPDATE: begin
            wr_en     = 1'b1;
            wr_idx    = slot_ff;
            wr_stride = new_stride_in;
            wr_mode   = upd_mode;
            state_in  = (upd_mode == MODE_NOPRED) ? FS_IDLE : FS_STEP;
         end
         FS_STEP: begin
            if (!job_valid || job_ready) begin
               state_in = FS_IDLE;
            end
         end
         default: begin
            state_in = FS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= FS_IDLE;
         degree_ff  <= DEGREE_RESET;
         block_ff   <= BLOCK_RESET;
         counter_ff <= '0;
         valid_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (csr.valid && csr.ready) begin
            if (csr.index == CSR_DEGREE) begin
               degree_ff <= csr.data[DEGREE_BITS-1:0];
            end else if (csr.index == CSR_BLOCK_SIZE) begin
               block_ff <= csr.data[BLOCK_BITS-1:0];
            end
         end
         if (req.valid && req.ready) begin
            counter_ff <= counter_ff + 1'b1;
         end
         if (wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         has_pc_ff <= req.has_pc;
         pc_ff     <= req.pc;
         addr_ff   <= req.access_addr;
      end
      if (wr_en) begin
         tag_ff[wr_idx]    <= pc_ff;
         prev_ff[wr_idx]   <= wr_prev;
         stride_ff[wr_idx] <= wr_stride;
         mode_ff[wr_idx]   <= wr_mode;
         stamp_ff[wr_idx]  <= counter_ff;
      end
      slot_ff   <= slot_in;
      scan_ff   <= scan_in;
      victim_ff <= victim_in;
      best_ff   <= best_in;
      if (state_ff == FS_UPDATE) begin
         new_stride_ff <= new_stride_in;
      end
   end

endmodule

>>> rtl/spp_job_queue.sv
// Short FIFO of prefetch jobs between the front end and the address generator.
// Depends on spp_pkg.
module spp_job_queue
   import spp_pkg::*;
#(
   parameter int WIDTH = 105,
   parameter int DEPTH = JOB_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0] fill_ff;
   logic                do_push, do_pop;

   assign push_ready = (fill_ff != CNT_BITS'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/spp_back.sv
// Back end: walks one job, emitting base + d*step for d = 1..count, one per cycle while rsp is ready.
// Holds the result in an output register. Depends on spp_pkg and spp_if.
module spp_back
   import spp_pkg::*;
#(
   parameter int ADDR_BITS  = 48,
   parameter int MAX_DEGREE = 8,
   parameter int CNT_BITS   = $clog2(MAX_DEGREE + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   output logic                 job_ready,
   input  logic [ADDR_BITS-1:0] job_addr,
   input  logic [ADDR_BITS-1:0] job_step,
   input  logic [CNT_BITS-1:0]  job_count,
   spp_rsp_if.source            rsp
);

   logic                 active_ff;
   logic [ADDR_BITS-1:0] cur_ff;
   logic [ADDR_BITS-1:0] step_ff;
   logic [CNT_BITS-1:0]  idx_ff;
   logic [CNT_BITS-1:0]  count_ff;
   logic                 out_valid_ff;
   logic [ADDR_BITS-1:0] out_addr_ff;
   logic                 out_last_ff;
   logic                 load_out, at_end;

   assign job_ready         = !active_ff;
   assign load_out          = active_ff && (!out_valid_ff || rsp.ready);
   assign at_end            = (idx_ff == count_ff);
   assign rsp.valid         = out_valid_ff;
   assign rsp.prefetch_addr = out_addr_ff;
   assign rsp.last_of_run   = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (job_valid && job_ready) begin
            active_ff <= 1'b1;
         end else if (load_out && at_end) begin
            active_ff <= 1'b0;
         end
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_valid && job_ready) begin
         cur_ff   <= job_addr + job_step;
         step_ff  <= job_step;
         idx_ff   <= CNT_BITS'(1);
         count_ff <= job_count;
      end else if (load_out) begin
         cur_ff <= cur_ff + step_ff;
         idx_ff <= idx_ff + 1'b1;
      end
      if (load_out) begin
         out_addr_ff <= cur_ff;
         out_last_ff <= at_end;
      end
   end

endmodule

>>> rtl/stride_prefetch_predictor.sv
// Top level of the stride prefetch predictor: front end, job queue, address generator.
// Depends on spp_pkg, spp_if, spp_front, spp_job_queue and spp_back.
//
// req_bus takes one access (has_pc, pc, access_addr) per transfer; rsp_bus gives the
// prefetch addresses, last_of_run set on the final one of an access; csr_bus writes
// degree (index 0) and block_size (index 1) and is always ready.
// The front end takes one access at a time and is ready again after passing through:
//   lookup alone for an access without PC or a miss into a free slot;
//   lookup and stride update for a non-predicting hit;
//   lookup, stride update, step and job hand-off for a predicting hit;
//   lookup and the LRU scan for a miss on a full table, the scan reading one stamp
//   per cycle over all TABLE_ENTRIES entries.
// A predicting hit raises rsp_bus.valid once its job has passed the queue and the output
// register; further addresses follow one per cycle while rsp_bus is ready, and the
// next access overlaps with them through a two-entry job queue.
// Reset (synchronous, active high) empties the table, clears the use counter and sets
// degree 1, block_size 64; no clearing pass is needed.
// When rsp_bus stalls the result register holds, the generator waits, and once the
// queue fills the front end holds its job and stops taking accesses.
module stride_prefetch_predictor
   import spp_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16,
   parameter int ADDR_BITS     = 48,
   parameter int MAX_DEGREE    = 8
) (
   input logic       clock,
   input logic       reset,
   spp_req_if.sink   req_bus,
   spp_rsp_if.source rsp_bus,
   spp_csr_if.sink   csr_bus
);

   localparam int CNT_BITS = $clog2(MAX_DEGREE + 1);
   localparam int JOB_BITS = CNT_BITS + 2 * ADDR_BITS;

   logic                 push_valid, push_ready;
   logic                 pop_valid, pop_ready;
   logic [ADDR_BITS-1:0] f_addr, f_step, b_addr, b_step;
   logic [CNT_BITS-1:0]  f_count, b_count;
   logic [JOB_BITS-1:0]  push_data, pop_data;

   spp_front #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .ADDR_BITS     (ADDR_BITS),
      .MAX_DEGREE    (MAX_DEGREE),
      .CNT_BITS      (CNT_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .csr       (csr_bus),
      .job_valid (push_valid),
      .job_ready (push_ready),
      .job_addr  (f_addr),
      .job_step  (f_step),
      .job_count (f_count)
   );

   assign push_data = {f_count, f_step, f_addr};

   spp_job_queue #(
      .WIDTH (JOB_BITS),
      .DEPTH (JOB_QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign b_addr  = pop_data[ADDR_BITS-1:0];
   assign b_step  = pop_data[2*ADDR_BITS-1:ADDR_BITS];
   assign b_count = pop_data[JOB_BITS-1:2*ADDR_BITS];

   spp_back #(
      .ADDR_BITS  (ADDR_BITS),
      .MAX_DEGREE (MAX_DEGREE),
      .CNT_BITS   (CNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job_ready (pop_ready),
      .job_addr  (b_addr),
      .job_step  (b_step),
      .job_count (b_count),
      .rsp       (rsp_bus)
   );

endmodule

>>> rtl/spp_checker.sv
// Port-level checks on the stride prefetch predictor, bound to the top level.
// Depends on spp_pkg and stride_prefetch_predictor.
module spp_checker
   import spp_pkg::*;
#(
   parameter int ADDR_BITS = 48
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [ADDR_BITS-1:0] rsp_prefetch_addr,
   input logic                 rsp_last_of_run
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_prefetch_addr) && $stable(rsp_last_of_run))
      else $error("rsp payload changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_one_access: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second access taken before the first was classified");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=> rsp_valid)
      else $error("prefetch run broken before its last address");

endmodule

bind stride_prefetch_predictor spp_checker #(
   .ADDR_BITS (ADDR_BITS)
) u_spp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_prefetch_addr (rsp_bus.prefetch_addr),
   .rsp_last_of_run   (rsp_bus.last_of_run)
);
